>>> rtl/lpfs_pkg.sv
// Shared types and constants for the LED PWM frame serializer.
`timescale 1ns / 1ps
package lpfs_pkg;

    localparam int CHANNELS_DEF = 12;
    localparam int FRAME_BYTES  = 28;
    localparam int BRIGHT_W     = 7;
    localparam int CHAN_W       = 16;

    localparam logic [5:0] FRAME_MAGIC   = 6'h25;
    localparam logic [4:0] FRAME_CONTROL = 5'h16;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 7'h7F;

    // Configuration register indexes
    localparam logic [1:0] REG_RED   = 2'd0;
    localparam logic [1:0] REG_GREEN = 2'd1;
    localparam logic [1:0] REG_BLUE  = 2'd2;

    typedef enum logic [1:0] {
        CMD_SET_CH  = 2'd0,
        CMD_SET_LED = 2'd1,
        CMD_SEND    = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd        command;
        logic [3:0]  index;
        logic [15:0] value_a;
        logic [15:0] value_b;
        logic [15:0] value_c;
    } t_in_word;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_out_word;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic              wr_en;
        logic              load;
        logic              shift;
        logic [CHAN_W-1:0] wr_data;
    } t_cell_ctl;

endpackage

>>> rtl/lpfs_in_if.sv
// Command channel: valid/ready handshake carrying one command word.
`timescale 1ns / 1ps
interface lpfs_in_if;
    import lpfs_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/lpfs_out_if.sv
// Frame byte channel: valid/ready handshake carrying one frame byte word.
`timescale 1ns / 1ps
interface lpfs_out_if;
    import lpfs_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/lpfs_cell.sv
// One cell of the frame chain: a stored 16-bit word and a byte-wide shift stage.
`timescale 1ns / 1ps
module lpfs_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lpfs_pkg::t_cell_ctl i_ctl,
    input  logic [7:0]         i_byte,
    output logic [7:0]         o_byte
);
    import lpfs_pkg::*;

    logic [CHAN_W-1:0] r_value;
    logic [CHAN_W-1:0] r_shadow;

    // Hold the stored word; write it on a matching command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
        end else if (i_ctl.wr_en) begin
            r_value <= i_ctl.wr_data;
        end
    end

    // Snapshot on send, then advance one byte toward the head per shift.
    // Take the word being written this cycle, so header cells load live brightness.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_shadow <= i_ctl.wr_en ? i_ctl.wr_data : r_value;
        end else if (i_ctl.shift) begin
            r_shadow <= {r_shadow[7:0], i_byte};
        end
    end

    assign o_byte = r_shadow[CHAN_W-1:8];

endmodule

>>> rtl/led_pwm_frame_serializer.sv
// Top level of the LED PWM frame serializer: cell chain, sequencer and config.
//
// Usage:
//   i_cmd carries command words (set channel, set LED triple, send frame).
//   o_frame returns frame bytes, one word per byte, last_byte set on the 28th.
//   i_cfg_we/i_cfg_idx/i_cfg_data write the three 7-bit brightness registers.
// Timing:
//   Set-channel and set-LED words are taken one per cycle when no frame is streaming, and return nothing.
//   A send word snapshots all cells into the byte shift chain; the first byte
//   is valid the next cycle, and the chain advances one byte per accepted
//   output word. i_cmd.ready stays low while a frame is being streamed.
// Reset:
//   Channel values clear to zero, brightness registers to 127, no frame
//   pending. No clearing pass is needed.
// Stall:
//   When o_frame.ready is low the current byte holds and the chain stands
//   still; nothing is lost.
`timescale 1ns / 1ps
module led_pwm_frame_serializer #(
    parameter int CHANNELS = lpfs_pkg::CHANNELS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    lpfs_in_if.sink                    i_cmd,
    lpfs_out_if.source                 o_frame,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [lpfs_pkg::BRIGHT_W-1:0] i_cfg_data
);
    import lpfs_pkg::*;

    localparam int CHAIN     = CHANNELS + 2;
    localparam int FRAME_LEN = 2 * CHAIN;
    localparam int CNT_W     = $clog2(FRAME_LEN);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAME_LEN - 1);

    logic [BRIGHT_W-1:0] r_bright_red;
    logic [BRIGHT_W-1:0] r_bright_green;
    logic [BRIGHT_W-1:0] r_bright_blue;
    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;

    logic        w_in_acc;
    logic        w_out_acc;
    logic        w_send;
    logic [31:0] w_header;
    logic [5:0]  w_led_base;
    t_cell_ctl   w_ctl  [CHAIN];
    logic [7:0]  w_byte [CHAIN];

    assign w_in_acc  = i_cmd.valid && i_cmd.ready;
    assign w_out_acc = o_frame.valid && o_frame.ready;
    assign w_send    = w_in_acc && (i_cmd.data.command == CMD_SEND);

    // Brightness registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright_red   <= BRIGHT_RESET;
            r_bright_green <= BRIGHT_RESET;
            r_bright_blue  <= BRIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RED:   r_bright_red   <= i_cfg_data;
                REG_GREEN: r_bright_green <= i_cfg_data;
                REG_BLUE:  r_bright_blue  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_header   = {FRAME_MAGIC, FRAME_CONTROL, r_bright_red, r_bright_green,
                         r_bright_blue};
    assign w_led_base = {2'b00, i_cmd.data.index} + {1'b0, i_cmd.data.index, 1'b0};

    // Decode per-cell writes; header cells track the header every cycle
    always_comb begin
        for (int j = 0; j < CHAIN; j++) begin
            w_ctl[j].load    = w_send;
            w_ctl[j].shift   = w_out_acc;
            w_ctl[j].wr_en   = 1'b0;
            w_ctl[j].wr_data = i_cmd.data.value_a;
            if (j < CHANNELS) begin
                if (w_in_acc && i_cmd.data.command == CMD_SET_CH
                    && {2'b00, i_cmd.data.index} == 6'(j)) begin
                    w_ctl[j].wr_en = 1'b1;
                end
                if (w_in_acc && i_cmd.data.command == CMD_SET_LED) begin
                    if (w_led_base == 6'(j)) begin
                        w_ctl[j].wr_en = 1'b1;
                    end else if (w_led_base + 6'd1 == 6'(j)) begin
                        w_ctl[j].wr_en   = 1'b1;
                        w_ctl[j].wr_data = i_cmd.data.value_b;
                    end else if (w_led_base + 6'd2 == 6'(j)) begin
                        w_ctl[j].wr_en   = 1'b1;
                        w_ctl[j].wr_data = i_cmd.data.value_c;
                    end
                end
            end else begin
                w_ctl[j].wr_en   = 1'b1;
                w_ctl[j].wr_data = (j == CHANNELS) ? w_header[15:0] : w_header[31:16];
            end
        end
    end

    // Chain of cells: cell 0 at the tail, upper header cell at the head
    for (genvar g = 0; g < CHAIN; g++) begin : g_cell
        lpfs_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (w_ctl[g]),
            .i_byte ((g == 0) ? 8'h00 : w_byte[(g == 0) ? 0 : g - 1]),
            .o_byte (w_byte[g])
        );
    end

    // Frame sequencer: count bytes out, drop busy after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (w_send) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (w_out_acc) begin
            if (r_cnt == LAST_CNT) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign i_cmd.ready             = !r_busy;
    assign o_frame.valid           = r_busy;
    assign o_frame.data.frame_byte = w_byte[CHAIN-1];
    assign o_frame.data.last_byte  = (r_cnt == LAST_CNT);

    // Checks
    a_no_cmd_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame.valid |-> !i_cmd.ready)
        else $error("command accepted while a frame is streaming");

    a_first_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_send |=> (o_frame.valid && o_frame.data.frame_byte == {FRAME_MAGIC,
                                                                 FRAME_CONTROL[4:3]}))
        else $error("frame does not open with the header byte");

    a_end_of_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_frame.data.last_byte) |=> !o_frame.valid)
        else $error("bytes continue after the last byte");

    a_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && !o_frame.data.last_byte) |=> o_frame.valid)
        else $error("frame ended early");

endmodule

>>> tb/tb.sv
// Testbench for the LED PWM frame serializer: directed, random and back-pressure tests.
`timescale 1ns / 1ps
module tb;
    import lpfs_pkg::*;

    localparam int         NUM_CHANNELS  = 12;
    localparam int         STALL_LIMIT   = 2000;
    localparam int         SETTLE_CYCLES = 8;
    localparam logic [1:0] REG_SPARE     = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [BRIGHT_W-1:0] i_cfg_data;

    lpfs_in_if  cmd_if ();
    lpfs_out_if frame_if ();

    led_pwm_frame_serializer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_if),
        .o_frame    (frame_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the channel values and brightness registers
    logic [CHAN_W-1:0]   pwm_level [NUM_CHANNELS];
    logic [BRIGHT_W-1:0] bright_r;
    logic [BRIGHT_W-1:0] bright_g;
    logic [BRIGHT_W-1:0] bright_b;

    // Frame bytes still owed by the block, oldest first
    t_out_word frame_bytes_due [$];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_cycles = 0;
    int err_count = 0;
    int words_sent = 0;
    int frames_sent = 0;
    int bytes_checked = 0;
    int cfg_writes = 0;
    int idle_cycles = 0;

    // Clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Apply one channel write to the shadow store, dropping out-of-range channels
    function automatic void store_level(input int chan, input logic [CHAN_W-1:0] level);
        if (chan < NUM_CHANNELS) begin
            pwm_level[chan] = level;
        end
    endfunction

    // Predict the effect of one accepted command word
    function automatic void track_word(input t_in_word w);
        logic [31:0] header;
        header = {FRAME_MAGIC, FRAME_CONTROL, bright_r, bright_g, bright_b};
        case (w.command)
            CMD_SET_CH: begin
                store_level(int'(w.index), w.value_a);
            end
            CMD_SET_LED: begin
                store_level(int'(w.index) * 3, w.value_a);
                store_level(int'(w.index) * 3 + 1, w.value_b);
                store_level(int'(w.index) * 3 + 2, w.value_c);
            end
            CMD_SEND: begin
                frames_sent++;
                for (int k = 3; k >= 0; k--) begin
                    frame_bytes_due.push_back('{frame_byte: header[k*8 +: 8], last_byte: 1'b0});
                end
                for (int ch = NUM_CHANNELS - 1; ch >= 0; ch--) begin
                    frame_bytes_due.push_back('{frame_byte: pwm_level[ch][15:8],
                                                last_byte: 1'b0});
                    frame_bytes_due.push_back('{frame_byte: pwm_level[ch][7:0],
                                                last_byte: ch == 0});
                end
            end
            default: ;
        endcase
        words_sent++;
    endfunction

    function automatic t_in_word make_word(input t_cmd cmd, input int idx,
                                           input logic [15:0] a, input logic [15:0] b,
                                           input logic [15:0] c);
        t_in_word w;
        w.command = cmd;
        w.index   = idx[3:0];
        w.value_a = a;
        w.value_b = b;
        w.value_c = c;
        return w;
    endfunction

    // Mostly channel and LED writes, with sends and unused commands mixed in
    function automatic t_in_word random_word();
        int   pick;
        int   idx;
        t_cmd cmd;
        pick = $urandom_range(99);
        idx  = $urandom_range(15);
        if (pick < 40) begin
            cmd = CMD_SET_CH;
        end else if (pick < 75) begin
            cmd = CMD_SET_LED;
            if ($urandom_range(99) < 80) idx = $urandom_range(3);
        end else if (pick < 88) begin
            cmd = CMD_SEND;
        end else begin
            cmd = CMD_NONE;
        end
        return make_word(cmd, idx, 16'($urandom), 16'($urandom), 16'($urandom));
    endfunction

    // Offer one word, with random idle cycles first, and wait until it is taken
    task automatic put_word(input t_in_word w);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            cmd_if.valid = 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid = 1'b1;
        cmd_if.data  = w;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        track_word(w);
    endtask

    // Drop valid, drain every owed byte, then let the block settle
    task automatic wait_idle();
        @(negedge i_clk);
        cmd_if.valid = 1'b0;
        while (frame_bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [BRIGHT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        case (idx)
            REG_RED:   bright_r = val;
            REG_GREEN: bright_g = val;
            REG_BLUE:  bright_b = val;
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Frame after reset: default brightness, all channels zero
    task automatic test_reset_frame();
        put_word(make_word(CMD_SEND, 0, '0, '0, '0));
        wait_idle();
    endtask

    // Field extremes, every command and the out-of-range cases
    task automatic test_directed();
        put_word(make_word(CMD_SET_CH, 0, 16'hFFFF, 16'h0000, 16'h0000));
        put_word(make_word(CMD_SET_CH, 11, 16'h8001, 16'hFFFF, 16'hFFFF));
        put_word(make_word(CMD_SET_CH, 12, 16'h1234, 16'h0, 16'h0));
        put_word(make_word(CMD_SET_CH, 15, 16'hFFFF, 16'h0, 16'h0));
        put_word(make_word(CMD_SEND, 15, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        put_word(make_word(CMD_SET_LED, 0, 16'h0000, 16'hFFFF, 16'h5A5A));
        put_word(make_word(CMD_SET_LED, 1, 16'hA5A5, 16'h0001, 16'h8000));
        put_word(make_word(CMD_SET_LED, 2, 16'h00FF, 16'hFF00, 16'h7FFF));
        put_word(make_word(CMD_SET_LED, 3, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        put_word(make_word(CMD_SET_LED, 4, 16'h1111, 16'h2222, 16'h3333));
        put_word(make_word(CMD_SET_LED, 15, 16'h4444, 16'h5555, 16'h6666));
        put_word(make_word(CMD_NONE, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        put_word(make_word(CMD_NONE, 15, 16'h0000, 16'h0000, 16'h0000));
        put_word(make_word(CMD_SEND, 0, 16'h0, 16'h0, 16'h0));
        wait_idle();
        write_reg(REG_RED, 7'h00);
        write_reg(REG_GREEN, 7'h7F);
        write_reg(REG_BLUE, 7'h55);
        write_reg(REG_SPARE, 7'h00);
        put_word(make_word(CMD_SEND, 0, 16'h0, 16'h0, 16'h0));
        put_word(make_word(CMD_SET_CH, 5, 16'h0000, 16'h0, 16'h0));
        put_word(make_word(CMD_SEND, 0, 16'h0, 16'h0, 16'h0));
        wait_idle();
    endtask

    // Random words under one idle/stall setting, with new brightness first
    task automatic test_random_phase(input int tx_pct, input int rx_pct,
                                     input logic [BRIGHT_W-1:0] r,
                                     input logic [BRIGHT_W-1:0] g,
                                     input logic [BRIGHT_W-1:0] b, input int count);
        write_reg(REG_RED, r);
        write_reg(REG_GREEN, g);
        write_reg(REG_BLUE, b);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        for (int n = 0; n < count; n++) begin
            put_word(random_word());
        end
        put_word(make_word(CMD_SEND, $urandom_range(15), 16'($urandom), 16'($urandom),
                           16'($urandom)));
        wait_idle();
    endtask

    // Hold the receiver off while writes queue up behind a frame
    task automatic test_backpressure();
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        rx_hold_cycles = 300;
        put_word(make_word(CMD_SEND, 0, 16'h0, 16'h0, 16'h0));
        for (int n = 0; n < 4; n++) begin
            put_word(make_word(CMD_SET_LED, n, 16'($urandom), 16'($urandom),
                               16'($urandom)));
        end
        put_word(make_word(CMD_SEND, 0, 16'h0, 16'h0, 16'h0));
        wait_idle();
    endtask

    // Receiver: random stalls, or a held-off stretch when asked
    initial begin
        frame_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                frame_if.ready = 1'b0;
                rx_hold_cycles--;
            end else begin
                frame_if.ready = ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Check each accepted frame byte against the oldest owed byte
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && frame_if.valid && frame_if.ready) begin
            if (frame_bytes_due.size() == 0) begin
                $error("unexpected frame word: frame_byte %0h last_byte %0b",
                       frame_if.data.frame_byte, frame_if.data.last_byte);
                err_count++;
            end else begin
                want = frame_bytes_due.pop_front();
                bytes_checked++;
                if (frame_if.data.frame_byte !== want.frame_byte) begin
                    $error("frame_byte mismatch: expected %0h, got %0h",
                           want.frame_byte, frame_if.data.frame_byte);
                    err_count++;
                end
                if (frame_if.data.last_byte !== want.last_byte) begin
                    $error("last_byte mismatch: expected %0b, got %0b",
                           want.last_byte, frame_if.data.last_byte);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (frame_if.valid && frame_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = REG_RED;
        i_cfg_data     = '0;
        cmd_if.valid   = 1'b0;
        cmd_if.data    = '0;
        bright_r       = BRIGHT_RESET;
        bright_g       = BRIGHT_RESET;
        bright_b       = BRIGHT_RESET;
        for (int ch = 0; ch < NUM_CHANNELS; ch++) pwm_level[ch] = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_frame();
        test_directed();
        test_random_phase(0, 0, 7'h7F, 7'h00, 7'h7F, 21);
        test_random_phase(67, 0, 7'($urandom_range(127)), 7'($urandom_range(127)),
                          7'($urandom_range(127)), 21);
        test_random_phase(0, 67, 7'h00, 7'h00, 7'h00, 21);
        test_random_phase(19, 19, 7'($urandom_range(127)), 7'($urandom_range(127)),
                          7'($urandom_range(127)), 21);
        test_backpressure();

        $display("Covered %0d command words, %0d frames, %0d frame bytes checked,",
                 words_sent, frames_sent, bytes_checked);
        $display("%0d brightness writes, across four idle/stall mixes and a long hold-off.",
                 cfg_writes);
        if (err_count == 0 && frame_bytes_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/lpfs_pkg.sv
rtl/lpfs_in_if.sv
rtl/lpfs_out_if.sv
rtl/lpfs_cell.sv
rtl/led_pwm_frame_serializer.sv
tb/tb.sv
